// ===== hw/rtl/dhkv_pkg.sv =====
`default_nettype none

package dhkv_pkg;

    // Default sizes
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed field widths
    localparam int SIZE_W   = 11;
    localparam int PRIME_W  = 16;
    localparam int CFG_W    = 16;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 3;
    localparam int VOUT_W   = 32;
    localparam int OP_W     = 2;

    // Divisor width of the remainder unit: covers the step prime and the table size
    localparam int DVW = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Register indexes
    localparam logic CFG_TABLE_SIZE = 1'b0;
    localparam logic CFG_STEP_PRIME = 1'b1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERWRITE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    // Slot marks
    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD_KEY,
        S_MOD_STEP,
        S_READ,
        S_CHECK
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dhkv_rem.sv =====
`default_nettype none

// Bit-serial remainder: one dividend bit per cycle, done pulses with rem valid
module dhkv_rem
    import dhkv_pkg::*;
#(
    parameter int DW = 32
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [DW-1:0]  dividend,
    input  wire logic [DVW-1:0] divisor,
    output logic [DVW-1:0]      rem,
    output logic                done
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]  sh_reg,  sh_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           done_reg, done_next;
    logic [DVW:0]   trial;

    // Shift in the next bit and subtract the divisor where it fits
    always_comb
    begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, sh_reg[DW-1]};
        if (trial >= {1'b0, divisor})
        begin
            trial = trial - {1'b0, divisor};
        end
        if (start)
        begin
            sh_next  = dividend;
            rem_next = '0;
            cnt_next = CW'(DW);
        end
        else if (cnt_reg != '0)
        begin
            sh_next   = {sh_reg[DW-2:0], 1'b0};
            rem_next  = trial[DVW-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/double_hash_key_value_table.sv =====
`default_nettype none

// Open-addressing key/value table with double hashing. Pulse start with an
// operation (insert, search, delete) while busy is low; one result beat comes
// back on done and cannot be stalled. status/value_out stay put until the next
// request is accepted, entry_count until the next result. After reset the block
// sweeps all TABLE_DEPTH slots to empty, one slot per cycle, with busy high;
// registers may be written then.
// A request runs two bit-serial remainder passes (key mod size and key mod
// prime together, then step mod size), then probes slots one at a time: the
// slot memory is read in S_READ, then checked and written back in S_CHECK.
// Operation code 3 answers at once without busy going high.
module double_hash_key_value_table
    import dhkv_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [OP_W-1:0]        operation,
    input  wire logic [KEY_WIDTH-1:0]   key,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output logic                        done,
    output logic [STATUS_W-1:0]         status,
    output logic [VOUT_W-1:0]           value_out,
    output logic [COUNT_W-1:0]          entry_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (SW > SIZE_W) ? SW : SIZE_W;
    localparam int DW = (KEY_WIDTH > DVW) ? KEY_WIDTH : DVW;
    localparam int EW = 2 + KEY_WIDTH + VALUE_WIDTH;
    localparam int VX = (VALUE_WIDTH > VOUT_W) ? VALUE_WIDTH : VOUT_W;

    // Configuration
    logic [SIZE_W-1:0]  size_cfg_reg;
    logic [PRIME_W-1:0] prime_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg  <= SIZE_W'(1021);
            prime_cfg_reg <= PRIME_W'(7);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TABLE_SIZE: size_cfg_reg  <= cfg_data[SIZE_W-1:0];
                CFG_STEP_PRIME: prime_cfg_reg <= cfg_data[PRIME_W-1:0];
                default:        size_cfg_reg  <= size_cfg_reg;
            endcase
        end
    end

    // Clamp size to 1..TABLE_DEPTH and prime to at least 1
    logic [SW-1:0]      size_eff;
    logic [PRIME_W-1:0] prime_eff;
    logic [XW-1:0]      size_x;

    always_comb
    begin
        size_x = XW'(size_cfg_reg);
        if (size_cfg_reg == '0)
            size_eff = SW'(1);
        else if (size_x > XW'(TABLE_DEPTH))
            size_eff = SW'(TABLE_DEPTH);
        else
            size_eff = SW'(size_x);
        prime_eff = (prime_cfg_reg == '0) ? PRIME_W'(1) : prime_cfg_reg;
    end

    state_t state_reg, state_next;

    // Request registers
    logic [OP_W-1:0]        op_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [AW-1:0]          pos_reg, base_reg, stepm_reg, clr_reg;
    logic [SW-1:0]          att_reg;
    logic                   hit_reg;
    logic [COUNT_W-1:0]     count_reg;

    // Result registers
    logic                   done_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [VOUT_W-1:0]      vout_reg;

    // Remainder units
    logic           rs_start, rp_start, rs_done, rp_done;
    logic [DW-1:0]  rs_dividend;
    logic [DVW-1:0] rs_rem, rp_rem;
    logic [DVW-1:0] step_full;

    assign step_full = {1'b0, prime_eff} - rp_rem + DVW'(1);

    dhkv_rem #(.DW(DW)) u_rem_size
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rs_start),
        .dividend (rs_dividend),
        .divisor  (DVW'(size_eff)),
        .rem      (rs_rem),
        .done     (rs_done)
    );

    dhkv_rem #(.DW(DW)) u_rem_prime
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rp_start),
        .dividend (DW'(key)),
        .divisor  (DVW'(prime_eff)),
        .rem      (rp_rem),
        .done     (rp_done)
    );

    // Slot memory: mark, key, value
    logic [EW-1:0]  slot_mem [TABLE_DEPTH];
    logic [EW-1:0]  rd_q;
    logic           rd_en, wr_en;
    logic [AW-1:0]  wr_addr;
    logic [EW-1:0]  wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_q <= slot_mem[pos_reg];
    end

    mark_t                  q_mark;
    logic [KEY_WIDTH-1:0]   q_key;
    logic [VALUE_WIDTH-1:0] q_val;
    logic                   q_live, q_empty, q_match, last_att;

    assign q_mark   = mark_t'(rd_q[EW-1 -: 2]);
    assign q_key    = rd_q[KEY_WIDTH+VALUE_WIDTH-1 -: KEY_WIDTH];
    assign q_val    = rd_q[VALUE_WIDTH-1:0];
    assign q_live   = (q_mark == MARK_LIVE);
    assign q_empty  = (q_mark == MARK_EMPTY);
    assign q_match  = q_live && (q_key == key_reg);
    assign last_att = (att_reg == size_eff - SW'(1));

    // Next probe slot: one compare and subtract since both terms are below size
    logic [SW:0] pos_sum;
    logic [AW-1:0] pos_adv;

    always_comb
    begin
        pos_sum = (SW+1)'(pos_reg) + (SW+1)'(stepm_reg);
        if (pos_sum >= (SW+1)'(size_eff))
            pos_sum = pos_sum - (SW+1)'(size_eff);
        pos_adv = pos_sum[AW-1:0];
    end

    // Decide on the slot just read
    logic                chk_done, cnt_inc, cnt_dec;
    logic [STATUS_W-1:0] chk_status;
    logic [VX-1:0]       vout_x;

    always_comb
    begin
        chk_done   = 1'b0;
        chk_status = ST_NOT_FOUND;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        vout_x     = '0;
        case (op_reg)
            OP_INSERT:
            begin
                if (q_match)
                begin
                    chk_done   = 1'b1;
                    chk_status = ST_OVERWRITE;
                end
                else if (!q_live)
                begin
                    chk_done   = 1'b1;
                    chk_status = ST_INSERTED;
                    cnt_inc    = 1'b1;
                end
                else if (last_att)
                begin
                    chk_done   = 1'b1;
                    chk_status = ST_FULL;
                end
            end
            OP_SEARCH:
            begin
                if (q_match)
                begin
                    chk_done   = 1'b1;
                    chk_status = ST_FOUND;
                    vout_x     = VX'(q_val);
                end
                else if (q_empty || last_att)
                begin
                    chk_done = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (q_empty || last_att)
                begin
                    chk_done = 1'b1;
                    if (hit_reg || q_match)
                    begin
                        chk_status = ST_FOUND;
                        cnt_dec    = 1'b1;
                    end
                end
            end
            default:
            begin
                chk_done = 1'b1;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (clr_reg == AW'(TABLE_DEPTH - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (start && operation != OP_NONE)
                    state_next = S_MOD_KEY;
            S_MOD_KEY:
                if (rs_done)
                    state_next = S_MOD_STEP;
            S_MOD_STEP:
                if (rs_done)
                    state_next = S_READ;
            S_READ:
                state_next = S_CHECK;
            S_CHECK:
                state_next = chk_done ? S_IDLE : S_READ;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Memory and unit controls
    always_comb
    begin
        rs_start    = 1'b0;
        rp_start    = 1'b0;
        rs_dividend = DW'(key);
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = {MARK_LIVE, key_reg, val_reg};
        busy        = (state_reg != S_IDLE);
        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = {MARK_EMPTY, {(KEY_WIDTH + VALUE_WIDTH){1'b0}}};
            end
            S_IDLE:
            begin
                rs_start = start && (operation != OP_NONE);
                rp_start = rs_start;
            end
            S_MOD_KEY:
            begin
                rs_start    = rs_done;
                rs_dividend = DW'(step_full);
            end
            S_READ:
            begin
                rd_en = 1'b1;
            end
            S_CHECK:
            begin
                if (op_reg == OP_INSERT && (q_match || !q_live))
                    wr_en = 1'b1;
                if (op_reg == OP_DELETE && q_match)
                begin
                    wr_en   = 1'b1;
                    wr_data = {MARK_TOMB, q_key, q_val};
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == S_IDLE && start && operation == OP_NONE)
                done_reg <= 1'b1;
            if (state_reg == S_CHECK && chk_done)
            begin
                done_reg <= 1'b1;
                if (cnt_inc && count_reg != COUNT_MAX)
                    count_reg <= count_reg + 1'b1;
                if (cnt_dec && count_reg != '0)
                    count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_reg     <= operation;
                    key_reg    <= key;
                    val_reg    <= value;
                    status_reg <= ST_NOT_FOUND;
                    vout_reg   <= '0;
                end
            end
            S_MOD_KEY:
            begin
                if (rs_done)
                    base_reg <= rs_rem[AW-1:0];
            end
            S_MOD_STEP:
            begin
                if (rs_done)
                begin
                    stepm_reg <= rs_rem[AW-1:0];
                    pos_reg   <= base_reg;
                    att_reg   <= '0;
                    hit_reg   <= 1'b0;
                end
            end
            S_CHECK:
            begin
                if (q_match)
                    hit_reg <= 1'b1;
                pos_reg <= pos_adv;
                att_reg <= att_reg + 1'b1;
                if (chk_done)
                begin
                    status_reg <= chk_status;
                    vout_reg   <= vout_x[VOUT_W-1:0];
                end
            end
            default:
            begin
                hit_reg <= hit_reg;
            end
        endcase
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign value_out   = vout_reg;
    assign entry_count = count_reg;

    // Probe slot stays inside the active table
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (SW'(pos_reg) < size_eff))
        else $error("probe slot beyond table size");

    // Count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1)
        || (count_reg == $past(count_reg) - 1'b1))
        else $error("entry count jumped");

    // Result beat only goes out with the controller idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result beat while a request is in flight");

    // Both remainder units finish together
    a_rem_sync: assert property (@(posedge clk) disable iff (!rst_n)
        rp_done |-> rs_done)
        else $error("remainder units out of step");

endmodule

`default_nettype wire

// ===== tb/double_hash_key_value_table_tb.sv =====
`timescale 1ns / 1ps

module double_hash_key_value_table_tb;
    import dhkv_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;

    typedef struct {
        logic [STATUS_W-1:0] st;
        logic [VOUT_W-1:0]   vo;
        logic [COUNT_W-1:0]  cnt;
    } answer_t;

    typedef struct {
        bit                  reconf;
        logic [CFG_W-1:0]    size_w;
        logic [CFG_W-1:0]    prime_w;
        logic [OP_W-1:0]     op;
        logic [31:0]         k;
        logic [31:0]         v;
        bit                  typed;
        answer_t             ans;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     operation;
    logic [31:0]         key;
    logic [31:0]         value;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [VOUT_W-1:0]   value_out;
    logic [COUNT_W-1:0]  entry_count;

    // shadow copy of the table
    mark_t               shadow_mark [DEPTH];
    logic [31:0]         shadow_key [DEPTH];
    logic [31:0]         shadow_val [DEPTH];
    logic [COUNT_W-1:0]  live_entries;
    logic [SIZE_W-1:0]   shadow_size;
    logic [PRIME_W-1:0]  shadow_prime;

    answer_t             awaited_answers[$];
    int                  accepted_beats;
    int                  errors;
    bit                  typed_on;
    answer_t             typed_answer;
    row_t                directed[$];

    double_hash_key_value_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .key         (key),
        .value       (value),
        .done        (done),
        .status      (status),
        .value_out   (value_out),
        .entry_count (entry_count)
    );

    always #5 clk = ~clk;

    // walk the double-hash probe sequence and update the shadow table
    task automatic apply_request(input logic [OP_W-1:0] op, input logic [31:0] k,
                                 input logic [31:0] v, output answer_t r);
        longint unsigned sz, pr, base, stp, s, a;
        bit hit;
        sz = (shadow_size == 0) ? 1 : ((shadow_size > DEPTH) ? DEPTH : shadow_size);
        pr = (shadow_prime == 0) ? 1 : shadow_prime;
        base = k % sz;
        stp = pr - (k % pr) + 1;
        hit = 0;
        r.st = ST_NOT_FOUND;
        r.vo = '0;
        case (op)
            OP_INSERT:
            begin
                r.st = ST_FULL;
                for (a = 0; a < sz; a++)
                begin
                    s = (base + (a * stp) % sz) % sz;
                    if (shadow_mark[s] == MARK_LIVE)
                    begin
                        if (shadow_key[s] == k)
                        begin
                            shadow_val[s] = v;
                            r.st = ST_OVERWRITE;
                            break;
                        end
                    end
                    else
                    begin
                        shadow_mark[s] = MARK_LIVE;
                        shadow_key[s] = k;
                        shadow_val[s] = v;
                        if (live_entries != COUNT_MAX)
                            live_entries++;
                        r.st = ST_INSERTED;
                        break;
                    end
                end
            end
            OP_SEARCH:
            begin
                for (a = 0; a < sz; a++)
                begin
                    s = (base + (a * stp) % sz) % sz;
                    if (shadow_mark[s] == MARK_EMPTY)
                        break;
                    if (shadow_mark[s] == MARK_LIVE && shadow_key[s] == k)
                    begin
                        r.st = ST_FOUND;
                        r.vo = shadow_val[s];
                        break;
                    end
                end
            end
            OP_DELETE:
            begin
                // tombstone every live match along the walk
                for (a = 0; a < sz; a++)
                begin
                    s = (base + (a * stp) % sz) % sz;
                    if (shadow_mark[s] == MARK_EMPTY)
                        break;
                    if (shadow_mark[s] == MARK_LIVE && shadow_key[s] == k)
                    begin
                        shadow_mark[s] = MARK_TOMB;
                        hit = 1;
                    end
                end
                if (hit)
                begin
                    r.st = ST_FOUND;
                    if (live_entries != 0)
                        live_entries--;
                end
            end
            default:
            begin
            end
        endcase
        r.cnt = live_entries;
    endtask

    // track register writes, predict accepted beats, check result beats
    always @(posedge clk)
    begin : track
        answer_t want, got;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TABLE_SIZE)
                    shadow_size = cfg_data[SIZE_W-1:0];
                else
                    shadow_prime = cfg_data[PRIME_W-1:0];
            end
            if (start && !busy)
            begin
                apply_request(operation, key, value, want);
                if (typed_on)
                    want = typed_answer;
                awaited_answers.push_back(want);
                accepted_beats++;
            end
            if (done === 1'b1)
            begin
                got.st = status;
                got.vo = value_out;
                got.cnt = entry_count;
                if (awaited_answers.size() == 0)
                begin
                    $display("%0t: result beat with nothing awaited: status %0d", $time, status);
                    errors++;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (got.st !== want.st)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
                        errors++;
                    end
                    if (got.vo !== want.vo)
                    begin
                        $display("%0t: value_out expected %h actual %h", $time, want.vo, got.vo);
                        errors++;
                    end
                    if (got.cnt !== want.cnt)
                    begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.cnt, got.cnt);
                        errors++;
                    end
                end
            end
        end
    end

    // present one beat after random gaps, hold until taken
    task automatic issue(input logic [OP_W-1:0] op, input logic [31:0] k,
                         input logic [31:0] v, input int idle_pct);
        int seen;
        seen = accepted_beats;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        operation <= op;
        key <= k;
        value <= v;
        do @(negedge clk); while (accepted_beats == seen);
    endtask

    // hold off until every awaited beat has come back
    task automatic drain();
        start <= 1'b0;
        while (awaited_answers.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] size_w, input logic [CFG_W-1:0] prime_w);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_TABLE_SIZE;
        cfg_data <= size_w;
        @(negedge clk);
        cfg_index <= CFG_STEP_PRIME;
        cfg_data <= prime_w;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic row_t mk(bit rc, int sz, int pr, logic [OP_W-1:0] op, logic [31:0] k,
                                logic [31:0] v, bit ty, logic [STATUS_W-1:0] st,
                                logic [31:0] vo, int cnt);
        row_t r;
        r.reconf = rc;
        r.size_w = CFG_W'(sz);
        r.prime_w = CFG_W'(pr);
        r.op = op;
        r.k = k;
        r.v = v;
        r.typed = ty;
        r.ans.st = st;
        r.ans.vo = vo;
        r.ans.cnt = COUNT_W'(cnt);
        return r;
    endfunction

    function automatic logic [31:0] pick_key(ref logic [31:0] pool[$]);
        if ($urandom_range(9) == 0 || pool.size() == 0)
            return $urandom;
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return OP_INSERT;
        if (r < 75)
            return OP_SEARCH;
        if (r < 95)
            return OP_DELETE;
        return OP_NONE;
    endfunction

    initial
    begin
        int sizes[] = '{1, 2, 3, 5, 7, 11, 13, 17, 31, 64, 97};
        int primes[] = '{0, 1, 2, 3, 5, 7, 13, 65535};
        logic [31:0] pool[$];
        int done_items, chunk, idle_pct, sz, pr, n, i;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TABLE_SIZE;
        cfg_data = '0;
        start = 1'b0;
        operation = OP_INSERT;
        key = '0;
        value = '0;
        typed_on = 1'b0;
        typed_answer = '{default: '0};
        errors = 0;
        accepted_beats = 0;
        live_entries = '0;
        shadow_size = 11'd1021;
        shadow_prime = 16'd7;
        foreach (shadow_mark[j])
        begin
            shadow_mark[j] = MARK_EMPTY;
            shadow_key[j] = '0;
            shadow_val[j] = '0;
        end

        // directed: empty table at reset settings
        directed.push_back(mk(0, 0, 0, OP_SEARCH, 32'h0, 32'h0, 1, ST_NOT_FOUND, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                              ST_NOT_FOUND, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_DELETE, 32'h1234_5678, 32'h0, 1, ST_NOT_FOUND, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                              ST_INSERTED, 0, 1));
        directed.push_back(mk(0, 0, 0, OP_SEARCH, 32'hFFFF_FFFF, 32'h0, 1,
                              ST_FOUND, 32'hFFFF_FFFF, 1));
        directed.push_back(mk(0, 0, 0, OP_INSERT, 32'hFFFF_FFFF, 32'h0, 1, ST_OVERWRITE, 0, 1));
        directed.push_back(mk(0, 0, 0, OP_DELETE, 32'hFFFF_FFFF, 32'h0, 1, ST_FOUND, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_SEARCH, 32'hFFFF_FFFF, 32'h0, 1, ST_NOT_FOUND, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_INSERT, 32'h0, 32'h0, 1, ST_INSERTED, 0, 1));
        // zero size and zero prime act as one: single slot
        directed.push_back(mk(1, 0, 0, OP_INSERT, 32'h5, 32'h1, 1, ST_FULL, 0, 1));
        directed.push_back(mk(0, 0, 0, OP_SEARCH, 32'h0, 32'h0, 1, ST_FOUND, 0, 1));
        directed.push_back(mk(0, 0, 0, OP_DELETE, 32'h0, 32'h0, 1, ST_FOUND, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_INSERT, 32'h5, 32'hA5A5_A5A5, 1, ST_INSERTED, 0, 1));
        directed.push_back(mk(0, 0, 0, OP_INSERT, 32'h6, 32'h0, 1, ST_FULL, 0, 1));
        directed.push_back(mk(0, 0, 0, OP_SEARCH, 32'h6, 32'h0, 1, ST_NOT_FOUND, 0, 1));
        // oversized table clamps to full depth, widest prime
        directed.push_back(mk(1, 16'hFFFF, 16'hFFFF, OP_INSERT, 32'h0, 32'h1, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_INSERT, 32'd1024, 32'h2, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_INSERT, 32'd2048, 32'h3, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_DELETE, 32'h0, 32'h0, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_SEARCH, 32'd2048, 32'h0, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_INSERT, 32'h8000_0000, 32'h5555_AAAA, 0, 0, 0, 0));
        // small prime table with collisions and tombstones
        directed.push_back(mk(1, 13, 5, OP_INSERT, 32'd13, 32'h7, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_INSERT, 32'd26, 32'h8, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_DELETE, 32'd13, 32'h0, 0, 0, 0, 0));
        directed.push_back(mk(0, 0, 0, OP_SEARCH, 32'd26, 32'h0, 0, 0, 0, 0));

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[j])
        begin
            if (directed[j].reconf)
                configure(directed[j].size_w, directed[j].prime_w);
            typed_on = directed[j].typed;
            typed_answer = directed[j].ans;
            issue(directed[j].op, directed[j].k, directed[j].v, 0);
        end
        typed_on = 1'b0;

        // random phases, each with its own settings and key pool
        done_items = 0;
        while (done_items < 1900)
        begin
            if ($urandom_range(7) == 0)
            begin
                sz = $urandom_range(1, 3) == 1 ? 2047 : $urandom_range(1000, 1024);
                chunk = 15;
            end
            else
            begin
                sz = sizes[$urandom_range(sizes.size() - 1)];
                chunk = $urandom_range(40, 120);
            end
            pr = ($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                          : primes[$urandom_range(primes.size() - 1)];
            // stray upper bits of the size write are dropped by the register
            configure({(CFG_W - SIZE_W)'($urandom_range(31)), sz[SIZE_W-1:0]}, CFG_W'(pr));
            pool.delete();
            n = (sz > 64) ? 12 : $urandom_range(2, 2 * sz + 2);
            for (i = 0; i < n; i++)
                pool.push_back($urandom_range(1) ? $urandom : $urandom_range(0, 4 * sz));
            for (i = 0; i < chunk && done_items < 1900; i++)
            begin
                idle_pct = (done_items < 633) ? 12 : ((done_items < 1266) ? 82 : 0);
                issue(pick_op(), pick_key(pool), $urandom, idle_pct);
                done_items++;
            end
        end

        drain();
        repeat (200) @(negedge clk);
        if (errors == 0 && awaited_answers.size() == 0)
            $display("double_hash_key_value_table verification clean");
        else
            $display("double_hash_key_value_table verification failed");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("double_hash_key_value_table verification failed");
        $finish;
    end

endmodule
